>>> rtl/core/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// types and constants shared by the two-wire memory byte access master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] mem_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_missing;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  device_select;
      logic [15:0] ack_timeout;
      logic [15:0] post_stop_ticks;
   } cfg_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_TX_LO,
      PH_TX_HI,
      PH_ACK_LO,
      PH_ACK_HI,
      PH_RS_A,
      PH_RS_B,
      PH_RS_C,
      PH_RX_LO,
      PH_RX_HI,
      PH_NACK_LO,
      PH_NACK_HI,
      PH_STOP_A,
      PH_STOP_B,
      PH_STOP_C,
      PH_WAIT
   } phase_type;

   typedef enum logic [1:0] {
      STAGE_DEVICE,
      STAGE_ADDR,
      STAGE_DATA
   } stage_type;

   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   localparam logic [1:0] REG_DEVICE_SELECT   = 2'd0;
   localparam logic [1:0] REG_ACK_TIMEOUT     = 2'd1;
   localparam logic [1:0] REG_POST_STOP_TICKS = 2'd2;

   localparam logic [6:0]  DEVICE_SELECT_RESET   = 7'd80;
   localparam logic [15:0] ACK_TIMEOUT_RESET     = 16'd5000;
   localparam logic [15:0] POST_STOP_TICKS_RESET = 16'd250;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

>>> rtl/core/i2cee_fsm.sv
// ----------------------------------------------------------------------------
// i2cee_fsm
// bus sequencer: one tick per request, drives the bus levels and status
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_fsm
   import i2cee_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_fire,
   input  wire req_type req_data,
   input  wire cfg_type cfg,
   output rsp_type      rsp_data
);

   phase_type   phase_ff, phase_in;
   stage_type   stage_ff, stage_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [7:0]  captured_ff, captured_in;
   logic [15:0] wait_count_ff, wait_count_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  saved_addr_ff, saved_addr_in;
   logic [7:0]  saved_data_ff, saved_data_in;
   logic        timeout_ff, timeout_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         stage_ff      <= STAGE_DEVICE;
         bit_index_ff  <= '0;
         shift_byte_ff <= '0;
         captured_ff   <= '0;
         wait_count_ff <= '0;
         is_read_ff    <= 1'b0;
         saved_addr_ff <= '0;
         saved_data_ff <= '0;
         timeout_ff    <= 1'b0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         stage_ff      <= stage_in;
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         captured_ff   <= captured_in;
         wait_count_ff <= wait_count_in;
         is_read_ff    <= is_read_in;
         saved_addr_ff <= saved_addr_in;
         saved_data_ff <= saved_data_in;
         timeout_ff    <= timeout_in;
      end
   end

   logic [3:0]  bit_next;
   logic [15:0] wait_next;
   logic        scl, sl, dr, busy, done;

   assign bit_next  = bit_index_ff + 4'd1;
   assign wait_next = wait_count_ff + 16'd1;

   always_comb begin
      phase_in      = phase_ff;
      stage_in      = stage_ff;
      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      captured_in   = captured_ff;
      wait_count_in = wait_count_ff;
      is_read_in    = is_read_ff;
      saved_addr_in = saved_addr_ff;
      saved_data_in = saved_data_ff;
      timeout_in    = timeout_ff;
      scl  = 1'b1;
      sl   = 1'b1;
      dr   = 1'b1;
      busy = 1'b1;
      done = 1'b0;

      case (phase_ff)
         PH_TX_LO: begin
            scl      = 1'b0;
            sl       = shift_byte_ff[7];
            phase_in = PH_TX_HI;
         end
         PH_TX_HI: begin
            sl            = shift_byte_ff[7];
            shift_byte_in = {shift_byte_ff[6:0], 1'b0};
            bit_index_in  = bit_next;
            phase_in      = (bit_next >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_LO;
         end
         PH_ACK_LO: begin
            scl           = 1'b0;
            sl            = 1'b0;
            dr            = 1'b0;
            wait_count_in = '0;
            phase_in      = PH_ACK_HI;
         end
         PH_ACK_HI: begin
            sl = 1'b0;
            dr = 1'b0;
            if (req_data.sda_in && (wait_count_ff < cfg.ack_timeout)) begin
               wait_count_in = wait_next;
            end else begin
               if (req_data.sda_in) begin
                  timeout_in = 1'b1;
               end
               // continue with the next byte, a repeated start, the read or the stop
               case (stage_ff)
                  STAGE_DEVICE: begin
                     stage_in      = STAGE_ADDR;
                     shift_byte_in = saved_addr_ff;
                     bit_index_in  = '0;
                     phase_in      = PH_TX_LO;
                  end
                  STAGE_ADDR: begin
                     if (is_read_ff) begin
                        phase_in = PH_RS_A;
                     end else begin
                        stage_in      = STAGE_DATA;
                        shift_byte_in = saved_data_ff;
                        bit_index_in  = '0;
                        phase_in      = PH_TX_LO;
                     end
                  end
                  default: begin
                     if (is_read_ff) begin
                        shift_byte_in = '0;
                        bit_index_in  = '0;
                        phase_in      = PH_RX_LO;
                     end else begin
                        phase_in = PH_STOP_A;
                     end
                  end
               endcase
            end
         end
         PH_RS_A: begin
            scl      = 1'b0;
            phase_in = PH_RS_B;
         end
         PH_RS_B: begin
            phase_in = PH_RS_C;
         end
         PH_RS_C: begin
            sl            = 1'b0;
            stage_in      = STAGE_DATA;
            shift_byte_in = {cfg.device_select, RW_READ};
            bit_index_in  = '0;
            phase_in      = PH_TX_LO;
         end
         PH_RX_LO: begin
            scl      = 1'b0;
            sl       = 1'b0;
            dr       = 1'b0;
            phase_in = PH_RX_HI;
         end
         PH_RX_HI: begin
            sl            = 1'b0;
            dr            = 1'b0;
            shift_byte_in = {shift_byte_ff[6:0], req_data.sda_in};
            bit_index_in  = bit_next;
            if (bit_next >= BITS_PER_BYTE) begin
               captured_in = {shift_byte_ff[6:0], req_data.sda_in};
               phase_in    = PH_NACK_LO;
            end else begin
               phase_in = PH_RX_LO;
            end
         end
         PH_NACK_LO: begin
            scl      = 1'b0;
            phase_in = PH_NACK_HI;
         end
         PH_NACK_HI: begin
            phase_in = PH_STOP_A;
         end
         PH_STOP_A: begin
            scl      = 1'b0;
            sl       = 1'b0;
            phase_in = PH_STOP_B;
         end
         PH_STOP_B: begin
            sl       = 1'b0;
            phase_in = PH_STOP_C;
         end
         PH_STOP_C: begin
            wait_count_in = '0;
            if (cfg.post_stop_ticks == '0) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            wait_count_in = wait_next;
            if (wait_next >= cfg.post_stop_ticks) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if ((req_data.kind == KIND_WRITE) || (req_data.kind == KIND_READ)) begin
               is_read_in    = (req_data.kind == KIND_READ);
               saved_addr_in = req_data.mem_addr;
               saved_data_in = req_data.write_data;
               timeout_in    = 1'b0;
               stage_in      = STAGE_DEVICE;
               wait_count_in = '0;
               sl            = 1'b0;
               shift_byte_in = {cfg.device_select, RW_WRITE};
               bit_index_in  = '0;
               phase_in      = PH_TX_LO;
            end else begin
               busy = 1'b0;
            end
         end
      endcase

      rsp_data.scl_level   = scl;
      rsp_data.sda_level   = sl;
      rsp_data.sda_drive   = dr;
      rsp_data.busy_res    = busy;
      rsp_data.done_res    = done;
      rsp_data.read_byte   = captured_in;
      rsp_data.ack_missing = timeout_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/i2cee_outbuf.sv
// ----------------------------------------------------------------------------
// i2cee_outbuf
// result register with one skid entry to take one more request under stall
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_outbuf
   import i2cee_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop         = main_valid_ff && !rsp_stall;
   assign full        = skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/i2c_eeprom_byte_access_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_unit
// a result is formed combinationally from its request and the sequencer state, then registered in the result register
// throughput: one request per cycle while the skid entry is free, one result per request
// the sequencer state and a result register are the only stages
// reset: synchronous, active high; registers return to their reset values
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_byte_access_master_unit
   import i2cee_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic    req_fire;
   logic    buf_full;
   rsp_type step_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_DEVICE_SELECT:   cfg_in.device_select   = csr_pwdata[6:0];
            REG_ACK_TIMEOUT:     cfg_in.ack_timeout     = csr_pwdata[15:0];
            REG_POST_STOP_TICKS: cfg_in.post_stop_ticks = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_DEVICE_SELECT:   csr_prdata = {25'd0, cfg_ff.device_select};
         REG_ACK_TIMEOUT:     csr_prdata = {16'd0, cfg_ff.ack_timeout};
         REG_POST_STOP_TICKS: csr_prdata = {16'd0, cfg_ff.post_stop_ticks};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_select   <= DEVICE_SELECT_RESET;
         cfg_ff.ack_timeout     <= ACK_TIMEOUT_RESET;
         cfg_ff.post_stop_ticks <= POST_STOP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = buf_full;
   assign req_fire  = req_valid && !req_stall;

   i2cee_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_payload),
      .cfg      (cfg_ff),
      .rsp_data (step_rsp)
   );

   i2cee_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .push        (req_fire),
      .push_data   (step_rsp),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> bench/i2c_eeprom_byte_access_master_unit_test.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_unit_test
// drives half-bit ticks into the two-wire memory master, one request per
// tick, and compares every returned bus level set against a local model of
// the sequencer; directed accesses first, then random accesses under
// several register settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_byte_access_master_unit_test
   import i2cee_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int         ACK_NEVER  = 32'h7FFF_FFFF;

   typedef struct packed {
      bit         set_cfg;
      cfg_type    cfg;
      logic [1:0] kind;
      logic [7:0] addr;
      logic [7:0] data;
      int         ack_delay;
      logic [7:0] rx_data;
      bit         typed;
      rsp_type    want;
   } access_row_type;

   localparam rsp_type IDLE_BUS = '{scl_level: 1'b1, sda_level: 1'b1, sda_drive: 1'b1,
      busy_res: 1'b0, done_res: 1'b0, read_byte: 8'h00, ack_missing: 1'b0};

   localparam access_row_type DIRECTED_ROWS [15] = '{
      '{kind: KIND_TICK, typed: 1'b1, want: IDLE_BUS, default: 0},
      '{kind: KIND_SPARE, addr: 8'hFF, data: 8'hFF, typed: 1'b1, want: IDLE_BUS, default: 0},
      '{kind: KIND_WRITE, addr: 8'h00, data: 8'hFF, default: 0},
      '{set_cfg: 1'b1, cfg: '{DEVICE_SELECT_RESET, ACK_TIMEOUT_RESET, 16'd0},
        kind: KIND_READ, addr: 8'hFF, rx_data: 8'hA5, default: 0},
      '{set_cfg: 1'b1, cfg: '{7'd0, 16'd0, 16'd0}, kind: KIND_WRITE, addr: 8'h55,
        ack_delay: ACK_NEVER, default: 0},
      '{kind: KIND_TICK, default: 0},
      '{kind: KIND_READ, addr: 8'hAA, rx_data: 8'hFF, default: 0},
      '{kind: KIND_WRITE, addr: 8'h01, data: 8'h80, default: 0},
      '{kind: KIND_READ, addr: 8'h7F, ack_delay: ACK_NEVER, rx_data: 8'h00, default: 0},
      '{set_cfg: 1'b1, cfg: '{7'd127, 16'd3, 16'd1}, kind: KIND_READ, addr: 8'hC3,
        ack_delay: 2, rx_data: 8'h5A, default: 0},
      '{kind: KIND_WRITE, addr: 8'h3C, data: 8'h01, ack_delay: 3, default: 0},
      '{kind: KIND_WRITE, addr: 8'hFE, data: 8'h7F, ack_delay: 4, default: 0},
      '{set_cfg: 1'b1, cfg: '{7'h55, 16'hFFFF, 16'd4}, kind: KIND_WRITE, addr: 8'h80,
        data: 8'hC0, ack_delay: 40, default: 0},
      '{set_cfg: 1'b1, cfg: '{7'h2A, 16'd1, 16'd2}, kind: KIND_READ, addr: 8'h10,
        ack_delay: 1, rx_data: 8'h81, default: 0},
      '{kind: KIND_SPARE, default: 0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // model of the sequencer
   cfg_type    cfg_shadow = '{DEVICE_SELECT_RESET, ACK_TIMEOUT_RESET, POST_STOP_TICKS_RESET};
   phase_type  bus_phase = PH_IDLE;
   stage_type  byte_stage = STAGE_DEVICE;
   logic [3:0] bit_count = '0;
   logic [7:0] shift_reg = '0;
   logic [7:0] captured = '0;
   logic [15:0] wait_ticks = '0;
   logic       access_is_read = 1'b0;
   logic [7:0] held_addr = '0;
   logic [7:0] held_data = '0;
   logic       ack_lost = 1'b0;

   rsp_type predicted_ticks [$];
   int      ticks_sent = 0;
   int      idle_pct = 10;
   bit      failed = 1'b0;

   i2c_eeprom_byte_access_master_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #300_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic load_byte(input logic [7:0] value);
      shift_reg = value;
      bit_count = '0;
      bus_phase = PH_TX_LO;
   endtask

   task automatic advance_bus(input req_type r, output rsp_type o);
      o = '0;
      o.scl_level = 1'b1;
      o.sda_level = 1'b1;
      o.sda_drive = 1'b1;
      o.busy_res = 1'b1;
      case (bus_phase)
         PH_TX_LO: begin
            o.scl_level = 1'b0;
            o.sda_level = shift_reg[7];
            bus_phase = PH_TX_HI;
         end
         PH_TX_HI: begin
            o.sda_level = shift_reg[7];
            shift_reg = {shift_reg[6:0], 1'b0};
            bit_count = bit_count + 4'd1;
            bus_phase = (bit_count >= BITS_PER_BYTE) ? PH_ACK_LO : PH_TX_LO;
         end
         PH_ACK_LO: begin
            o.scl_level = 1'b0;
            o.sda_level = 1'b0;
            o.sda_drive = 1'b0;
            wait_ticks = '0;
            bus_phase = PH_ACK_HI;
         end
         PH_ACK_HI: begin
            o.sda_level = 1'b0;
            o.sda_drive = 1'b0;
            if (!r.sda_in || wait_ticks >= cfg_shadow.ack_timeout) begin
               if (r.sda_in) ack_lost = 1'b1;
               case (byte_stage)
                  STAGE_DEVICE: begin
                     byte_stage = STAGE_ADDR;
                     load_byte(held_addr);
                  end
                  STAGE_ADDR: begin
                     if (access_is_read) begin
                        bus_phase = PH_RS_A;
                     end else begin
                        byte_stage = STAGE_DATA;
                        load_byte(held_data);
                     end
                  end
                  default: begin
                     if (access_is_read) begin
                        shift_reg = '0;
                        bit_count = '0;
                        bus_phase = PH_RX_LO;
                     end else begin
                        bus_phase = PH_STOP_A;
                     end
                  end
               endcase
            end else begin
               wait_ticks = wait_ticks + 16'd1;
            end
         end
         PH_RS_A: begin
            o.scl_level = 1'b0;
            bus_phase = PH_RS_B;
         end
         PH_RS_B: bus_phase = PH_RS_C;
         PH_RS_C: begin
            o.sda_level = 1'b0;
            byte_stage = STAGE_DATA;
            load_byte({cfg_shadow.device_select, RW_READ});
         end
         PH_RX_LO: begin
            o.scl_level = 1'b0;
            o.sda_level = 1'b0;
            o.sda_drive = 1'b0;
            bus_phase = PH_RX_HI;
         end
         PH_RX_HI: begin
            o.sda_level = 1'b0;
            o.sda_drive = 1'b0;
            shift_reg = {shift_reg[6:0], r.sda_in};
            bit_count = bit_count + 4'd1;
            if (bit_count >= BITS_PER_BYTE) begin
               captured = shift_reg;
               bus_phase = PH_NACK_LO;
            end else begin
               bus_phase = PH_RX_LO;
            end
         end
         PH_NACK_LO: begin
            o.scl_level = 1'b0;
            bus_phase = PH_NACK_HI;
         end
         PH_NACK_HI: bus_phase = PH_STOP_A;
         PH_STOP_A: begin
            o.scl_level = 1'b0;
            o.sda_level = 1'b0;
            bus_phase = PH_STOP_B;
         end
         PH_STOP_B: begin
            o.sda_level = 1'b0;
            bus_phase = PH_STOP_C;
         end
         PH_STOP_C: begin
            wait_ticks = '0;
            if (cfg_shadow.post_stop_ticks == 16'd0) begin
               o.done_res = 1'b1;
               bus_phase = PH_IDLE;
            end else begin
               bus_phase = PH_WAIT;
            end
         end
         PH_WAIT: begin
            wait_ticks = wait_ticks + 16'd1;
            if (wait_ticks >= cfg_shadow.post_stop_ticks) begin
               o.done_res = 1'b1;
               bus_phase = PH_IDLE;
            end
         end
         default: begin
            bus_phase = PH_IDLE;
            if (r.kind == KIND_WRITE || r.kind == KIND_READ) begin
               access_is_read = (r.kind == KIND_READ);
               held_addr = r.mem_addr;
               held_data = r.write_data;
               ack_lost = 1'b0;
               byte_stage = STAGE_DEVICE;
               wait_ticks = '0;
               o.sda_level = 1'b0;
               load_byte({cfg_shadow.device_select, RW_WRITE});
            end else begin
               o.busy_res = 1'b0;
            end
         end
      endcase
      o.read_byte = captured;
      o.ack_missing = ack_lost;
   endtask

   task automatic send_tick(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type got;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_bus(item, got);
      predicted_ticks.push_back(typed ? want : got);
      ticks_sent++;
   endtask

   task automatic csr_access(input logic [1:0] index, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write_check(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] readback;
      csr_access(index, 1'b1, value, readback);
      csr_access(index, 1'b0, '0, readback);
      if (readback !== value) begin
         failed = 1'b1;
         $display("%0t: register %0d expected %0h actual %0h", $time, index, value, readback);
      end
   endtask

   task automatic apply_cfg(input cfg_type c);
      req_valid <= 1'b0;
      while (predicted_ticks.size() != 0) @(posedge clock);
      csr_write_check(REG_DEVICE_SELECT, {25'd0, c.device_select});
      csr_write_check(REG_ACK_TIMEOUT, {16'd0, c.ack_timeout});
      csr_write_check(REG_POST_STOP_TICKS, {16'd0, c.post_stop_ticks});
      cfg_shadow = c;
   endtask

   // one row: an optional register change, the request tick, then ticks until idle
   task automatic run_row(input access_row_type row);
      req_type item;
      int      acks_held;
      if (row.set_cfg) apply_cfg(row.cfg);
      item.kind = row.kind;
      item.mem_addr = row.addr;
      item.write_data = row.data;
      item.sda_in = 1'($urandom_range(0, 1));
      send_tick(item, row.typed, row.want);
      acks_held = 0;
      while (bus_phase != PH_IDLE) begin
         item.kind = 2'($urandom_range(0, 3));
         item.mem_addr = 8'($urandom);
         item.write_data = 8'($urandom);
         case (bus_phase)
            PH_ACK_HI: begin
               item.sda_in = (acks_held >= row.ack_delay) ? 1'b0 : 1'b1;
               acks_held++;
            end
            PH_RX_HI: item.sda_in = row.rx_data[3'(4'd7 - bit_count)];
            default: item.sda_in = 1'($urandom_range(0, 1));
         endcase
         if (bus_phase == PH_ACK_LO) acks_held = 0;
         send_tick(item, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : result_stall
      int stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(1, 18);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin : compare_ticks
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_ticks.size() == 0) begin
            failed = 1'b1;
            $display("%0t: unexpected result expected none actual %0h", $time, rsp_payload);
         end else begin
            want = predicted_ticks.pop_front();
            if (rsp_payload !== want) begin
               failed = 1'b1;
               $display("%0t: result expected %0h actual %0h", $time, want, rsp_payload);
            end
         end
      end
   end

   initial begin : stimulus
      access_row_type row;
      cfg_type        c;
      int             start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) run_row(DIRECTED_ROWS[i]);

      for (int seg = 0; seg < 4; seg++) begin
         c.device_select = 7'($urandom_range(0, 127));
         c.ack_timeout = 16'($urandom_range(0, 6));
         c.post_stop_ticks = 16'($urandom_range(0, 5));
         apply_cfg(c);
         idle_pct = (seg == 0) ? 8 : (seg == 1) ? 30 : 0;
         start = ticks_sent;
         while (ticks_sent - start < 40) begin
            row = '0;
            row.addr = 8'($urandom);
            row.data = 8'($urandom);
            row.rx_data = 8'($urandom);
            if ($urandom_range(0, 9) < 8) begin
               row.kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
               case ($urandom_range(0, 9))
                  0: row.ack_delay = ACK_NEVER;
                  1: row.ack_delay = $urandom_range(0, c.ack_timeout + 1);
                  default: row.ack_delay = $urandom_range(0, 2);
               endcase
            end else begin
               row.kind = $urandom_range(0, 1) ? KIND_SPARE : KIND_TICK;
            end
            run_row(row);
         end
      end

      req_valid <= 1'b0;
      while (predicted_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
